// File: rtl/core/rld_pkg.sv
// Shared types, widths, constants and helpers for the radial lens distortion block.
// Used by rld_mul, rld_radial and radial_lens_distortion; no dependencies.
package rld_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int CENTER_WIDTH = 15;
  localparam int SCALE_WIDTH  = 16;
  localparam int RECIP_WIDTH  = 32;
  localparam int COEF_WIDTH   = 32;
  localparam int CFG_WIDTH    = 32;
  localparam int REG_IDX_W    = 3;

  // centered coordinate: pixel minus center, one sign bit above the wider operand
  localparam int DIFF_WIDTH =
    ((COORD_WIDTH > CENTER_WIDTH + 1) ? COORD_WIDTH : CENTER_WIDTH + 1) + 1;

  // signed Q.28 intermediates, limited to +-(2^62 - 1)
  localparam int QW   = 63;
  localparam int FRAC = 28;
  localparam int LO_W = 32;
  localparam int HI_W = QW - LO_W;
  localparam int PW   = 2 * QW;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [4:0] shamt_t;

  localparam q_t Q_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_ONE = {{(QW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  localparam shamt_t SH_NORM   = 5'd8;
  localparam shamt_t SH_FRAC   = 5'd28;
  localparam shamt_t SH_DENORM = 5'd24;

  // pipeline depths
  localparam int MUL_LAT = 4;
  localparam int RAD_LAT = 4 * MUL_LAT + 3;
  localparam int VLD_LEN = 1 + 3 * MUL_LAT + RAD_LAT;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_SCALE,
    REG_RECIP_SCALE,
    REG_K1,
    REG_K2,
    REG_K3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] k1;
    logic signed [COEF_WIDTH-1:0] k2;
    logic signed [COEF_WIDTH-1:0] k3;
  } coef_t;

  typedef struct packed {
    logic                          action;
    logic signed [COORD_WIDTH-1:0] pixel_x;
    logic signed [COORD_WIDTH-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          saturated;
  } result_t;

  // sum of two limited Q.28 values, clamped back to the limit
  function automatic q_t add_sat(input q_t a, input q_t b);
    logic signed [QW:0] s;
    s = (QW+1)'(a) + (QW+1)'(b);
    if (s > (QW+1)'(Q_LIM)) begin
      return Q_LIM;
    end
    if (s < -(QW+1)'(Q_LIM)) begin
      return -Q_LIM;
    end
    return s[QW-1:0];
  endfunction

endpackage

// File: rtl/core/rld_mul.sv
// Four-stage signed multiply, right shift and limit for Q.28 operands.
// Depends on rld_pkg; built from 32-bit partial products.
module rld_mul (
  input  logic            clk,
  input  logic            en,
  input  rld_pkg::q_t     a,
  input  rld_pkg::q_t     b,
  input  rld_pkg::shamt_t sh,
  output rld_pkg::q_t     p
);
  import rld_pkg::*;

  logic [QW-1:0]        ma;
  logic [QW-1:0]        mb;
  logic                 neg1;
  logic [2*LO_W-1:0]    ll;
  logic [LO_W+HI_W-1:0] lh;
  logic [LO_W+HI_W-1:0] hl;
  logic [2*HI_W-1:0]    hh;
  logic                 neg2;
  logic [PW-1:0]        prod;
  logic                 neg3;
  logic [PW-1:0]        sft;
  logic                 ovf;
  logic [QW-2:0]        mag_r;

  always_comb begin
    sft   = prod >> sh;
    ovf   = |sft[PW-1:QW-1];
    mag_r = ovf ? Q_LIM[QW-2:0] : sft[QW-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split into magnitude and sign, then truncate toward zero on the magnitude
      ma   <= a[QW-1] ? -a : a;
      mb   <= b[QW-1] ? -b : b;
      neg1 <= a[QW-1] ^ b[QW-1];

      ll   <= ma[LO_W-1:0] * mb[LO_W-1:0];
      lh   <= ma[LO_W-1:0] * mb[QW-1:LO_W];
      hl   <= ma[QW-1:LO_W] * mb[LO_W-1:0];
      hh   <= ma[QW-1:LO_W] * mb[QW-1:LO_W];
      neg2 <= neg1;

      prod <= PW'(ll) + (PW'(lh) << LO_W) + (PW'(hl) << LO_W) + (PW'(hh) << (2 * LO_W));
      neg3 <= neg2;

      p    <= neg3 ? -q_t'({1'b0, mag_r}) : q_t'({1'b0, mag_r});
    end
  end

endmodule

// File: rtl/core/rld_radial.sv
// Radial factor pipeline: r2, r4, r6, the k1/k2/k3 polynomial and 1 +- sum.
// Depends on rld_pkg and rld_mul.
module rld_radial (
  input  logic          clk,
  input  logic          en,
  input  rld_pkg::q_t   u,
  input  rld_pkg::q_t   v,
  input  logic          action,
  input  rld_pkg::coef_t coef,
  output rld_pkg::q_t   f
);
  import rld_pkg::*;

  localparam int R2_DLY  = MUL_LAT;
  localparam int K1_DLY  = MUL_LAT;
  localparam int S12_DLY = MUL_LAT - 1;
  localparam int ACT_DLY = 4 * MUL_LAT + 2;

  q_t   uu;
  q_t   vv;
  q_t   r2;
  q_t   r4;
  q_t   r6;
  q_t   k1r2;
  q_t   k2r4;
  q_t   k3r6;
  q_t   s12;
  q_t   t;
  q_t   r2_dly   [R2_DLY];
  q_t   k1r2_dly [K1_DLY];
  q_t   s12_dly  [S12_DLY];
  logic act_dly  [ACT_DLY];

  rld_mul u_mul_uu (.clk(clk), .en(en), .a(u), .b(u), .sh(SH_FRAC), .p(uu));
  rld_mul u_mul_vv (.clk(clk), .en(en), .a(v), .b(v), .sh(SH_FRAC), .p(vv));

  rld_mul u_mul_r4 (.clk(clk), .en(en), .a(r2), .b(r2), .sh(SH_FRAC), .p(r4));
  rld_mul u_mul_k1 (
    .clk(clk), .en(en), .a(QW'(coef.k1)), .b(r2), .sh(SH_FRAC), .p(k1r2)
  );

  rld_mul u_mul_r6 (
    .clk(clk), .en(en), .a(r4), .b(r2_dly[R2_DLY-1]), .sh(SH_FRAC), .p(r6)
  );
  rld_mul u_mul_k2 (
    .clk(clk), .en(en), .a(QW'(coef.k2)), .b(r4), .sh(SH_FRAC), .p(k2r4)
  );

  rld_mul u_mul_k3 (
    .clk(clk), .en(en), .a(QW'(coef.k3)), .b(r6), .sh(SH_FRAC), .p(k3r6)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r2  <= add_sat(uu, vv);
      s12 <= add_sat(k1r2_dly[K1_DLY-1], k2r4);
      t   <= add_sat(s12_dly[S12_DLY-1], k3r6);
      // undistort takes 1 minus the sum
      f   <= add_sat(Q_ONE, act_dly[ACT_DLY-1] ? -t : t);

      r2_dly[0]   <= r2;
      k1r2_dly[0] <= k1r2;
      s12_dly[0]  <= s12;
      act_dly[0]  <= action;
      for (int i = 1; i < R2_DLY; i++) begin
        r2_dly[i] <= r2_dly[i-1];
      end
      for (int i = 1; i < K1_DLY; i++) begin
        k1r2_dly[i] <= k1r2_dly[i-1];
      end
      for (int i = 1; i < S12_DLY; i++) begin
        s12_dly[i] <= s12_dly[i-1];
      end
      for (int i = 1; i < ACT_DLY; i++) begin
        act_dly[i] <= act_dly[i-1];
      end
    end
  end

endmodule

// File: rtl/core/radial_lens_distortion.sv
// Radial lens distortion top level: configuration registers, centering,
// normalization, output scaling, clamping and the pipeline control.
// Depends on rld_pkg, rld_mul and rld_radial.
//
// Usage:
//   pixel channel: pixel_valid / pixel_stall / pixel (action, pixel_x, pixel_y).
//   result channel: result_valid / result_stall / result (out_x, out_y, saturated).
//   A transfer happens on a rising edge with valid high and stall low.
//   cfg_write / cfg_index / cfg_data write one register per cycle; write only
//   while no pixel is in flight. Unknown indexes are dropped.
//   From pixel transfer to result_valid a pair passes one centering
//   stage, three four-stage multipliers outside the radial chain (normalize,
//   apply the factor, denormalize), the radial factor chain and the output
//   register.
//   Throughput is one pair per cycle while pixel_stall is low; every multiplier is fully pipelined.
//   When the receiver stalls, the result holds in the output register and the
//   pipeline keeps moving until an item reaches the last stage; only then is
//   pixel_stall raised. Nothing is lost or repeated.
//   Reset (synchronous, rst high) empties the pipeline and loads the register
//   defaults: center 6400 / 4800, scale 1000, reciprocal 4294967, k1..k3 zero.
module radial_lens_distortion (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  rld_pkg::pixel_t                 pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output rld_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [rld_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [rld_pkg::CFG_WIDTH-1:0]   cfg_data
);
  import rld_pkg::*;

  localparam logic signed [QW:0] C_HI = (QW+1)'(2 ** (COORD_WIDTH - 1) - 1);
  localparam logic signed [QW:0] C_LO = (QW+1)'(-(2 ** (COORD_WIDTH - 1)));

  logic [CENTER_WIDTH-1:0] center_x;
  logic [CENTER_WIDTH-1:0] center_y;
  logic [SCALE_WIDTH-1:0]  scale;
  logic [RECIP_WIDTH-1:0]  recip_scale;
  coef_t                   coef;

  logic                         en;
  logic                         out_load;
  logic [VLD_LEN-1:0]           vld;
  logic signed [DIFF_WIDTH-1:0] dx;
  logic signed [DIFF_WIDTH-1:0] dy;
  logic                         act_dly [MUL_LAT+1];
  q_t                           u;
  q_t                           v;
  q_t                           u_dly [RAD_LAT];
  q_t                           v_dly [RAD_LAT];
  q_t                           f;
  q_t                           uf;
  q_t                           vf;
  q_t                           den_x;
  q_t                           den_y;
  logic [COORD_WIDTH:0]         cl_x;
  logic [COORD_WIDTH:0]         cl_y;
  result_t                      result_next;

  // add the center back and clamp; returns {clamped, value}
  function automatic logic [COORD_WIDTH:0] clamp_coord(input q_t den,
                                                       input logic [CENTER_WIDTH-1:0] c);
    logic signed [QW:0] s;
    s = (QW+1)'(den) + (QW+1)'($signed({1'b0, c}));
    if (s > C_HI) begin
      return {1'b1, C_HI[COORD_WIDTH-1:0]};
    end
    if (s < C_LO) begin
      return {1'b1, C_LO[COORD_WIDTH-1:0]};
    end
    return {1'b0, s[COORD_WIDTH-1:0]};
  endfunction

  assign out_load    = !result_valid || !result_stall;
  // hold everything only when the last stage has an item it cannot hand over
  assign en          = !vld[VLD_LEN-1] || out_load;
  assign pixel_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= CENTER_WIDTH'(6400);
      center_y    <= CENTER_WIDTH'(4800);
      scale       <= SCALE_WIDTH'(1000);
      recip_scale <= RECIP_WIDTH'(4294967);
      coef        <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:    center_x    <= cfg_data[CENTER_WIDTH-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[CENTER_WIDTH-1:0];
        REG_SCALE:       scale       <= cfg_data[SCALE_WIDTH-1:0];
        REG_RECIP_SCALE: recip_scale <= cfg_data[RECIP_WIDTH-1:0];
        REG_K1:          coef.k1     <= cfg_data[COEF_WIDTH-1:0];
        REG_K2:          coef.k2     <= cfg_data[COEF_WIDTH-1:0];
        REG_K3:          coef.k3     <= cfg_data[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLD_LEN-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx         <= DIFF_WIDTH'(pixel.pixel_x) - DIFF_WIDTH'($signed({1'b0, center_x}));
      dy         <= DIFF_WIDTH'(pixel.pixel_y) - DIFF_WIDTH'($signed({1'b0, center_y}));
      act_dly[0] <= pixel.action;
      for (int i = 1; i <= MUL_LAT; i++) begin
        act_dly[i] <= act_dly[i-1];
      end
      u_dly[0] <= u;
      v_dly[0] <= v;
      for (int i = 1; i < RAD_LAT; i++) begin
        u_dly[i] <= u_dly[i-1];
        v_dly[i] <= v_dly[i-1];
      end
    end
  end

  rld_mul u_mul_nx (
    .clk(clk), .en(en), .a(QW'(dx)), .b(QW'({1'b0, recip_scale})), .sh(SH_NORM), .p(u)
  );
  rld_mul u_mul_ny (
    .clk(clk), .en(en), .a(QW'(dy)), .b(QW'({1'b0, recip_scale})), .sh(SH_NORM), .p(v)
  );

  rld_radial u_radial (
    .clk(clk), .en(en), .u(u), .v(v), .action(act_dly[MUL_LAT]), .coef(coef), .f(f)
  );

  rld_mul u_mul_fx (
    .clk(clk), .en(en), .a(u_dly[RAD_LAT-1]), .b(f), .sh(SH_FRAC), .p(uf)
  );
  rld_mul u_mul_fy (
    .clk(clk), .en(en), .a(v_dly[RAD_LAT-1]), .b(f), .sh(SH_FRAC), .p(vf)
  );

  rld_mul u_mul_dx (
    .clk(clk), .en(en), .a(uf), .b(QW'({1'b0, scale})), .sh(SH_DENORM), .p(den_x)
  );
  rld_mul u_mul_dy (
    .clk(clk), .en(en), .a(vf), .b(QW'({1'b0, scale})), .sh(SH_DENORM), .p(den_y)
  );

  always_comb begin
    cl_x                  = clamp_coord(den_x, center_x);
    cl_y                  = clamp_coord(den_y, center_y);
    result_next.out_x     = cl_x[COORD_WIDTH-1:0];
    result_next.out_y     = cl_y[COORD_WIDTH-1:0];
    result_next.saturated = cl_x[COORD_WIDTH] | cl_y[COORD_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= vld[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[VLD_LEN-1]) begin
      result <= result_next;
    end
  end

  // a new result only comes from an item that sat in the last stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(vld[VLD_LEN-1]))
    else $error("result appeared without an item in the last stage");

  // an item blocked in the last stage stays there
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (vld[VLD_LEN-1] && pixel_stall) |=> vld[VLD_LEN-1])
    else $error("blocked item dropped from the last stage");

  // reset empties the pipeline and the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0 && !result_valid))
    else $error("pipeline not empty after reset");

endmodule
